// ===== hdl/cdll_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdll_pkg
// shared types and constants of the cursor doubly linked list
// ----------------------------------------------------------------------------
package cdll_pkg;
    localparam int CAPACITY   = 256;
    localparam int VALUE_BITS = 32;
    localparam int SLOT_BITS  = $clog2(CAPACITY);
    localparam int LINK_BITS  = SLOT_BITS + 1;
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);
    localparam int OUT_BITS   = 32;

    localparam logic [LINK_BITS-1:0] NIL = LINK_BITS'(CAPACITY);

    typedef enum logic [3:0] {
        ACT_QUERY      = 4'd0,
        ACT_PREPEND    = 4'd1,
        ACT_APPEND     = 4'd2,
        ACT_INS_BEFORE = 4'd3,
        ACT_INS_AFTER  = 4'd4,
        ACT_DEL_FRONT  = 4'd5,
        ACT_DEL_BACK   = 4'd6,
        ACT_DEL_CURSOR = 4'd7,
        ACT_TO_FRONT   = 4'd8,
        ACT_TO_BACK    = 4'd9,
        ACT_PREV       = 4'd10,
        ACT_NEXT       = 4'd11,
        ACT_CLEAR      = 4'd12
    } action_t;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // one memory word per node: value, prev and next link
    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [LINK_BITS-1:0]  prev;
        logic [LINK_BITS-1:0]  next;
    } node_t;

    localparam int NODE_BITS = $bits(node_t);
endpackage
`default_nettype wire

// ===== hdl/cdll_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdll_ram
// generic simple dual-port ram (one write port, one read port) with registered read
// ----------------------------------------------------------------------------
module cdll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/cursor_doubly_linked_list_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cursor_doubly_linked_list_top
// bounded doubly linked list of signed values with a cursor
// ----------------------------------------------------------------------------
// sequence: one decode read of the node ram, up to three link writes,
//   then reads of the front, back and cursor values from the node ram
// throughput: one transaction at a time, busy is low again in the strobe cycle
// reset: list empty, cursor set to none, node and free-slot rams left as is
// the receiver cannot stall: result is shown for one cycle with done
module cursor_doubly_linked_list_top (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [3:0]          action,
    input  wire logic signed [31:0]  data_value,
    output logic                     done,
    output logic [1:0]               status,
    output logic [8:0]               item_count,
    output logic signed [8:0]        cursor_position,
    output logic signed [31:0]       front_value,
    output logic signed [31:0]       back_value,
    output logic signed [31:0]       cursor_value
);
    import cdll_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_RD1    = 8'b0000_0010,  // read node needed for the first link edit
        S_WR1    = 8'b0000_0100,  // write new node, patch first node or push freed slot
        S_WR2    = 8'b0000_1000,  // write new or second neighbor node
        S_RDF    = 8'b0001_0000,  // read front
        S_RDB    = 8'b0010_0000,  // read back
        S_RDC    = 8'b0100_0000,  // read cursor
        S_OUT    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // list control state
    logic [LINK_BITS-1:0]  head_reg, head_next, tail_reg, tail_next;
    logic [LINK_BITS-1:0]  cur_reg, cur_next;
    logic signed [8:0]     cidx_reg, cidx_next;
    logic [COUNT_BITS-1:0] len_reg, len_next;
    logic [COUNT_BITS-1:0] fcnt_reg, fcnt_next;
    logic [COUNT_BITS-1:0] fresh_reg, fresh_next;

    // transaction registers
    action_t               act_reg, act_next;
    logic [VALUE_BITS-1:0] dat_reg, dat_next;
    logic [1:0]            st_reg, st_next;
    logic [LINK_BITS-1:0]  tgt_reg, tgt_next;   // node whose links are read
    logic [LINK_BITS-1:0]  new_reg, new_next;   // slot of new node
    logic [OUT_BITS-1:0]   fv_reg, fv_next, bv_reg, bv_next, cv_reg, cv_next;

    // node ram
    logic                  n_we;
    logic [SLOT_BITS-1:0]  n_waddr, n_raddr;
    node_t                 n_wdata, n_rdata;

    // free-slot stack ram
    logic                  f_we;
    logic [SLOT_BITS-1:0]  f_waddr, f_raddr;
    logic [SLOT_BITS-1:0]  f_wdata, f_rdata;

    cdll_ram #(.WIDTH(NODE_BITS), .DEPTH(CAPACITY)) u_node_ram (
        .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
        .raddr(n_raddr), .rdata(n_rdata)
    );

    cdll_ram #(.WIDTH(SLOT_BITS), .DEPTH(CAPACITY)) u_free_ram (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(f_raddr), .rdata(f_rdata)
    );

    function automatic logic [OUT_BITS-1:0] shown(input logic [VALUE_BITS-1:0] v);
        shown = OUT_BITS'(signed'(v));
    endfunction

    logic full, empty, has_cur, alloc_free;
    logic [SLOT_BITS-1:0] alloc_slot;

    always_comb
    begin
        full       = (len_reg == COUNT_BITS'(CAPACITY));
        empty      = (len_reg == '0);
        has_cur    = (cur_reg != NIL);
        alloc_free = (fcnt_reg != '0);
        // stack top is read in idle, so f_rdata holds it in S_RD1
        alloc_slot = alloc_free ? f_rdata : fresh_reg[SLOT_BITS-1:0];
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        cur_next   = cur_reg;
        cidx_next  = cidx_reg;
        len_next   = len_reg;
        fcnt_next  = fcnt_reg;
        fresh_next = fresh_reg;
        act_next   = act_reg;
        dat_next   = dat_reg;
        st_next    = st_reg;
        tgt_next   = tgt_reg;
        new_next   = new_reg;
        fv_next    = fv_reg;
        bv_next    = bv_reg;
        cv_next    = cv_reg;
        n_we       = 1'b0;
        n_waddr    = '0;
        n_wdata    = n_rdata;
        n_raddr    = tgt_reg[SLOT_BITS-1:0];
        f_we       = 1'b0;
        f_waddr    = fcnt_reg[SLOT_BITS-1:0];
        f_wdata    = tgt_reg[SLOT_BITS-1:0];
        f_raddr    = fcnt_reg[SLOT_BITS-1:0] - 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    act_next   = action_t'(action);
                    dat_next   = data_value[VALUE_BITS-1:0];
                    st_next    = ST_DONE;
                    state_next = S_RD1;
                end
            end
            S_RD1:
            begin
                // decide, pick the node to read
                state_next = S_RDF;
                priority case (act_reg)
                    ACT_PREPEND, ACT_APPEND:
                    begin
                        if (full) st_next = ST_FULL;
                        else
                        begin
                            new_next   = {1'b0, alloc_slot};
                            tgt_next   = (act_reg == ACT_PREPEND) ? head_reg : tail_reg;
                            state_next = S_WR1;
                        end
                    end
                    ACT_INS_BEFORE, ACT_INS_AFTER:
                    begin
                        if (!has_cur) st_next = ST_IGNORED;
                        else if (full) st_next = ST_FULL;
                        else
                        begin
                            new_next   = {1'b0, alloc_slot};
                            tgt_next   = cur_reg;
                            state_next = S_WR1;
                        end
                    end
                    ACT_DEL_FRONT, ACT_DEL_BACK:
                    begin
                        if (empty) st_next = ST_IGNORED;
                        else
                        begin
                            tgt_next   = (act_reg == ACT_DEL_FRONT) ? head_reg : tail_reg;
                            state_next = S_WR1;
                        end
                    end
                    ACT_DEL_CURSOR, ACT_PREV, ACT_NEXT:
                    begin
                        if (!has_cur) st_next = ST_IGNORED;
                        else
                        begin
                            tgt_next   = cur_reg;
                            state_next = S_WR1;
                        end
                    end
                    ACT_TO_FRONT:
                    begin
                        if (empty) st_next = ST_IGNORED;
                        else
                        begin
                            cur_next  = head_reg;
                            cidx_next = 9'sd0;
                        end
                    end
                    ACT_TO_BACK:
                    begin
                        if (empty) st_next = ST_IGNORED;
                        else
                        begin
                            cur_next  = tail_reg;
                            cidx_next = signed'(9'(len_reg - 1'b1));
                        end
                    end
                    ACT_CLEAR:
                    begin
                        head_next  = NIL;
                        tail_next  = NIL;
                        len_next   = '0;
                        fcnt_next  = '0;
                        fresh_next = '0;
                        cur_next   = NIL;
                        cidx_next  = -9'sd1;
                    end
                    default: ;
                endcase
                // fetch the chosen node so S_WR1 sees it
                n_raddr = tgt_next[SLOT_BITS-1:0];
            end
            S_WR1:
            begin
                // n_rdata holds node tgt (for insert/delete/move) when valid
                state_next = S_RDF;
                priority case (act_reg)
                    ACT_PREPEND:
                    begin
                        n_we    = 1'b1;
                        n_waddr = new_reg[SLOT_BITS-1:0];
                        n_wdata = '{value: dat_reg, prev: NIL, next: head_reg};
                        if (head_reg == NIL) tail_next = new_reg;
                        else state_next = S_WR2;
                        head_next = new_reg;
                        cur_next  = new_reg;
                        cidx_next = 9'sd0;
                        len_next  = len_reg + 1'b1;
                        if (alloc_free) fcnt_next = fcnt_reg - 1'b1;
                        else fresh_next = fresh_reg + 1'b1;
                    end
                    ACT_APPEND:
                    begin
                        n_we    = 1'b1;
                        n_waddr = new_reg[SLOT_BITS-1:0];
                        n_wdata = '{value: dat_reg, prev: tail_reg, next: NIL};
                        if (tail_reg == NIL) head_next = new_reg;
                        else state_next = S_WR2;
                        tail_next = new_reg;
                        cur_next  = new_reg;
                        cidx_next = signed'(9'(len_reg));
                        len_next  = len_reg + 1'b1;
                        if (alloc_free) fcnt_next = fcnt_reg - 1'b1;
                        else fresh_next = fresh_reg + 1'b1;
                    end
                    ACT_INS_BEFORE:
                    begin
                        // write cursor node with new prev, then fix its old prev
                        n_we     = 1'b1;
                        n_waddr  = cur_reg[SLOT_BITS-1:0];
                        n_wdata  = n_rdata;
                        n_wdata.prev = new_reg;
                        tgt_next = n_rdata.prev;
                        if (n_rdata.prev == NIL) head_next = new_reg;
                        cidx_next = cidx_reg + 9'sd1;
                        len_next  = len_reg + 1'b1;
                        if (alloc_free) fcnt_next = fcnt_reg - 1'b1;
                        else fresh_next = fresh_reg + 1'b1;
                        state_next = S_WR2;
                    end
                    ACT_INS_AFTER:
                    begin
                        n_we     = 1'b1;
                        n_waddr  = cur_reg[SLOT_BITS-1:0];
                        n_wdata  = n_rdata;
                        n_wdata.next = new_reg;
                        tgt_next = n_rdata.next;
                        if (n_rdata.next == NIL) tail_next = new_reg;
                        len_next  = len_reg + 1'b1;
                        if (alloc_free) fcnt_next = fcnt_reg - 1'b1;
                        else fresh_next = fresh_reg + 1'b1;
                        state_next = S_WR2;
                    end
                    ACT_DEL_FRONT, ACT_DEL_BACK, ACT_DEL_CURSOR:
                    begin
                        // push slot, update head/tail, then fix neighbors
                        f_we     = 1'b1;
                        f_wdata  = tgt_reg[SLOT_BITS-1:0];
                        fcnt_next = fcnt_reg + 1'b1;
                        len_next  = len_reg - 1'b1;
                        if (n_rdata.prev == NIL) head_next = n_rdata.next;
                        if (n_rdata.next == NIL) tail_next = n_rdata.prev;
                        if (cur_reg == tgt_reg)
                        begin
                            cur_next  = NIL;
                            cidx_next = -9'sd1;
                        end
                        else if (act_reg == ACT_DEL_FRONT && has_cur)
                            cidx_next = cidx_reg - 9'sd1;
                        new_next = n_rdata.next;
                        tgt_next = n_rdata.prev;
                        if (n_rdata.prev != NIL || n_rdata.next != NIL)
                            state_next = S_WR2;
                    end
                    ACT_PREV:
                    begin
                        cur_next  = n_rdata.prev;
                        cidx_next = (n_rdata.prev == NIL) ? -9'sd1 : cidx_reg - 9'sd1;
                    end
                    ACT_NEXT:
                    begin
                        cur_next  = n_rdata.next;
                        cidx_next = (n_rdata.next == NIL) ? -9'sd1 : cidx_reg + 9'sd1;
                    end
                    default: ;
                endcase
                // read whatever S_WR2 needs
                priority case (act_reg)
                    ACT_PREPEND:    n_raddr = head_reg[SLOT_BITS-1:0];
                    ACT_APPEND:     n_raddr = tail_reg[SLOT_BITS-1:0];
                    ACT_INS_BEFORE: n_raddr = n_rdata.prev[SLOT_BITS-1:0];
                    ACT_INS_AFTER:  n_raddr = n_rdata.next[SLOT_BITS-1:0];
                    default:        n_raddr = n_rdata.prev[SLOT_BITS-1:0];
                endcase
            end
            S_WR2:
            begin
                // n_rdata holds the neighbor to patch
                state_next = S_RDF;
                n_we = 1'b1;
                priority case (act_reg)
                    ACT_PREPEND:
                    begin
                        n_waddr = tgt_reg[SLOT_BITS-1:0];
                        n_wdata = n_rdata;
                        n_wdata.prev = new_reg;
                    end
                    ACT_APPEND:
                    begin
                        n_waddr = tgt_reg[SLOT_BITS-1:0];
                        n_wdata = n_rdata;
                        n_wdata.next = new_reg;
                    end
                    ACT_INS_BEFORE:
                    begin
                        // new node, then patch old prev
                        n_waddr = new_reg[SLOT_BITS-1:0];
                        n_wdata = '{value: dat_reg, prev: tgt_reg, next: cur_reg};
                        if (tgt_reg != NIL) state_next = S_WR2;
                        act_next = ACT_APPEND;  // reuse append patch: prev.next = new
                    end
                    ACT_INS_AFTER:
                    begin
                        n_waddr = new_reg[SLOT_BITS-1:0];
                        n_wdata = '{value: dat_reg, prev: cur_reg, next: tgt_reg};
                        if (tgt_reg != NIL) state_next = S_WR2;
                        act_next = ACT_PREPEND; // next.prev = new
                    end
                    default:
                    begin
                        // delete: prev.next = next, then next.prev = prev
                        if (tgt_reg != NIL)
                        begin
                            n_waddr = tgt_reg[SLOT_BITS-1:0];
                            n_wdata = n_rdata;
                            n_wdata.next = new_reg;
                        end
                        else n_we = 1'b0;
                        if (new_reg != NIL)
                        begin
                            // swap roles so next pass patches next.prev
                            tgt_next   = new_reg;
                            new_next   = tgt_reg;
                            act_next   = ACT_PREPEND;
                            state_next = S_WR2;
                        end
                    end
                endcase
                // read for a further patch pass
                priority case (act_reg)
                    ACT_INS_BEFORE, ACT_INS_AFTER: n_raddr = tgt_reg[SLOT_BITS-1:0];
                    default:                       n_raddr = new_reg[SLOT_BITS-1:0];
                endcase
            end
            S_RDF:
            begin
                n_raddr    = head_reg[SLOT_BITS-1:0];
                state_next = S_RDB;
            end
            S_RDB:
            begin
                fv_next    = (head_reg == NIL) ? '1 : shown(n_rdata.value);
                n_raddr    = tail_reg[SLOT_BITS-1:0];
                state_next = S_RDC;
            end
            S_RDC:
            begin
                bv_next    = (tail_reg == NIL) ? '1 : shown(n_rdata.value);
                n_raddr    = cur_reg[SLOT_BITS-1:0];
                state_next = S_OUT;
            end
            S_OUT:
            begin
                cv_next    = (cur_reg == NIL) ? '1 : shown(n_rdata.value);
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // forwarding: a write in the same cycle as a read of the same entry
    // never occurs on paths that use the read data, since patches write
    // one node and read a different one

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= NIL;
            tail_reg  <= NIL;
            cur_reg   <= NIL;
            cidx_reg  <= -9'sd1;
            len_reg   <= '0;
            fcnt_reg  <= '0;
            fresh_reg <= '0;
            done      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            cur_reg   <= cur_next;
            cidx_reg  <= cidx_next;
            len_reg   <= len_next;
            fcnt_reg  <= fcnt_next;
            fresh_reg <= fresh_next;
            done      <= (state_reg == S_OUT);
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg <= act_next;
        dat_reg <= dat_next;
        st_reg  <= st_next;
        tgt_reg <= tgt_next;
        new_reg <= new_next;
        fv_reg  <= fv_next;
        bv_reg  <= bv_next;
        cv_reg  <= cv_next;
    end

    always_comb
    begin
        status          = st_reg;
        item_count      = 9'(len_reg);
        cursor_position = cidx_reg;
        front_value     = signed'(fv_reg);
        back_value      = signed'(bv_reg);
        cursor_value    = signed'(cv_reg);
    end
endmodule
`default_nettype wire
